### hw/rtl/pfgw_pkg.sv
// shared types, constants, font table and helper functions of the page frame store glyph writer
`default_nettype none

package pfgw_pkg;

	// default geometry of the frame store
	localparam int COLUMNS_DEF = 128;
	localparam int ROWS_DEF    = 64;
	localparam int GLYPH_W     = 5;

	// port field widths
	localparam int OP_W       = 2;
	localparam int PIX_X_W    = 7;
	localparam int PIX_Y_W    = 6;
	localparam int CODE_W     = 8;
	localparam int PAGE_IDX_W = 3;
	localparam int COL_IDX_W  = 7;
	localparam int DATA_W     = 8;

	// font coverage
	localparam int FIRST_CODE = 32;
	localparam int LAST_CODE  = 127;
	localparam int GLYPH_CNT  = LAST_CODE - FIRST_CODE + 1;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_CNT);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR     = 2'd0,
		OP_SET_PIXEL = 2'd1,
		OP_PUT_CHAR  = 2'd2,
		OP_READ_BYTE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_READ,
		ST_CHAR,
		ST_DONE
	} state_t;

	// one row per glyph, leftmost column in the top byte
	localparam logic [GLYPH_W*8-1:0] GLYPH_ROM [GLYPH_CNT] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_56_20_50, 40'h08_07_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_B0_70_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h72_49_49_49_46, 40'h21_41_49_4D_33,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_31, 40'h41_21_11_09_07,
		40'h36_49_49_49_36, 40'h46_49_49_29_1E, 40'h00_00_14_00_00, 40'h00_40_34_00_00,
		40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_59_09_06,
		40'h3E_41_5D_59_4E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_41_3E, 40'h7F_49_49_49_49, 40'h7F_09_09_09_09, 40'h3E_41_41_51_73,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h26_49_49_49_32,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
		40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
		40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
		40'h07_0B_00_00_00, 40'h20_54_54_78_40, 40'h7F_28_44_44_38, 40'h38_44_44_44_28,
		40'h38_44_44_28_7F, 40'h38_54_54_54_18, 40'h00_08_7E_09_02, 40'h18_A4_A4_9C_78,
		40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_40_3D_00, 40'h7F_10_28_44_00,
		40'h00_41_7F_40_00, 40'h7C_04_78_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
		40'hFC_18_24_24_18, 40'h18_24_24_18_FC, 40'h7C_08_04_04_08, 40'h48_54_54_54_24,
		40'h04_04_3F_44_24, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
		40'h44_28_10_28_44, 40'h4C_90_90_90_7C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
		40'h00_00_77_00_00, 40'h00_41_36_08_00, 40'h04_02_04_08_04, 40'h00_7F_41_7F_00
	};

	// font row index, unsupported codes fall back to space
	function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] rel;
		begin
			rel = code - CODE_W'(FIRST_CODE);
			if (code < CODE_W'(FIRST_CODE) || code > CODE_W'(LAST_CODE)) begin
				glyph_index = '0;
			end else begin
				glyph_index = rel[GLYPH_IDX_W-1:0];
			end
		end
	endfunction

	// bit reversal of one byte by nibble, pair and bit swaps
	function automatic logic [DATA_W-1:0] mirror_byte(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		begin
			t = {v[3:0], v[7:4]};
			t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
			t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
			mirror_byte = t;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/page_framebuffer_glyph_writer_unit.sv
// top level of the page frame store glyph writer: sequencer, store and result register
`default_nettype none

// Monochrome page frame store of COLUMNS columns by ROWS/8 pages, one byte per
// column and page, bit 7 being the top pixel of a page, with a 96-glyph 5-column
// font for codes 32 to 127 (others draw as space). Items come in on the item
// channel (valid/stall) and each returns one byte on the result channel; only a
// read byte returns stored data, bit-reversed while rotated is set. All store
// accesses share one single-port ram, so a set pixel and a read byte go through
// read, modify or capture, and hand-off, a put char through setup, five glyph
// column writes and hand-off, and a clear writes all COLUMNS*2^PAGE_W ram entries,
// one ram entry per cycle. After reset the same sweep clears the store before the
// first item is taken; the rotated register is writable throughout. A new item
// is taken while the previous result still waits in the output register.
module page_framebuffer_glyph_writer_unit #(
	parameter int COLUMNS = pfgw_pkg::COLUMNS_DEF,
	parameter int ROWS    = pfgw_pkg::ROWS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [pfgw_pkg::OP_W-1:0]        operation,
	input  wire logic [pfgw_pkg::PIX_X_W-1:0]     pixel_x,
	input  wire logic [pfgw_pkg::PIX_Y_W-1:0]     pixel_y,
	input  wire logic [pfgw_pkg::CODE_W-1:0]      char_code,
	input  wire logic [pfgw_pkg::PAGE_IDX_W-1:0]  page_index,
	input  wire logic [pfgw_pkg::COL_IDX_W-1:0]   column_index,
	// result channel
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic      [pfgw_pkg::DATA_W-1:0]      read_data,
	// configuration channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_data
);

	import pfgw_pkg::*;

	localparam int PAGES     = ROWS / 8;
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W    = COL_W + PAGE_W;
	localparam int DEPTH     = COLUMNS * (1 << PAGE_W);
	localparam int CUR_W     = COL_W + 2;
	localparam int CNT_W     = $clog2(GLYPH_W);
	localparam int LIMIT_W   = COL_W + 2;

	state_t              state_q, state_d;
	logic                rotated_q;
	logic                result_valid_q;
	logic [DATA_W-1:0]   result_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                clr_from_op_q;
	logic [CNT_W-1:0]    gcnt_q;

	// captured item
	logic [DATA_W-1:0]        mask_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     loc_ok_q;
	logic [GLYPH_W*8-1:0]     glyph_row_q;
	logic [CUR_W-1:0]         cursor_q;
	logic [PAGE_W-1:0]        gpage_q;
	logic [DATA_W-1:0]        pend_q;

	// ram port
	logic                mem_en;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [DATA_W-1:0]   mem_wdata;
	logic [DATA_W-1:0]   mem_rdata;

	logic                item_acc;
	logic                pix_ok;
	logic                loc_ok;
	logic                cur_in;
	logic                out_free;
	logic [ADDR_W-1:0]   pix_addr;
	logic [ADDR_W-1:0]   loc_addr;
	logic [CNT_W-1:0]    byte_sel;

	assign item_acc = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	// range checks on the incoming item
	assign pix_ok = ({2'b00, pixel_x} < LIMIT_W'(COLUMNS)) &&
	                ({1'b0, pixel_y[5:3]} < 4'(PAGES));
	assign loc_ok = ({2'b00, column_index} < LIMIT_W'(COLUMNS)) &&
	                ({1'b0, page_index} < 4'(PAGES));

	assign pix_addr = {COL_W'(pixel_x), PAGE_W'(pixel_y[5:3])};
	assign loc_addr = {COL_W'(column_index), PAGE_W'(page_index)};

	// glyph column cursor lies inside the store
	assign cur_in   = !cursor_q[CUR_W-1] && (cursor_q < CUR_W'(COLUMNS));
	assign byte_sel = CNT_W'(GLYPH_W - 1) - gcnt_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotated_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rotated_q <= cfg_data;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram access
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = clr_addr_q;
		mem_wdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = clr_from_op_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					unique case (op_t'(operation))
						OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						OP_SET_PIXEL: begin
							mem_en   = pix_ok;
							mem_addr = pix_addr;
							state_d  = pix_ok ? ST_PIX : ST_DONE;
						end
						OP_PUT_CHAR: begin
							state_d = ST_CHAR;
						end
						OP_READ_BYTE: begin
							mem_en   = loc_ok;
							mem_addr = loc_addr;
							state_d  = ST_READ;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_PIX: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = addr_q;
				mem_wdata = mem_rdata | mask_q;
				state_d   = ST_DONE;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_CHAR: begin
				mem_en    = loc_ok_q && cur_in;
				mem_we    = 1'b1;
				mem_addr  = {cursor_q[COL_W-1:0], gpage_q};
				mem_wdata = glyph_row_q[8*byte_sel +: 8];
				if (gcnt_q == CNT_W'(GLYPH_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sweep counter and glyph column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			clr_from_op_q <= 1'b0;
			gcnt_q        <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end else begin
				clr_addr_q <= '0;
			end
			if (item_acc) begin
				clr_from_op_q <= 1'b1;
			end
			if (state_q == ST_CHAR) begin
				gcnt_q <= gcnt_q + 1'b1;
			end else begin
				gcnt_q <= '0;
			end
		end
	end

	// item capture and glyph cursor stepping
	always_ff @(posedge clk) begin
		if (item_acc) begin
			mask_q      <= 8'h80 >> pixel_y[2:0];
			addr_q      <= pix_addr;
			loc_ok_q    <= loc_ok;
			glyph_row_q <= GLYPH_ROM[glyph_index(char_code)];
			pend_q      <= '0;
			if (rotated_q) begin
				cursor_q <= CUR_W'(COLUMNS) - CUR_W'(column_index);
				gpage_q  <= PAGE_W'(PAGES - 1) - PAGE_W'(page_index);
			end else begin
				cursor_q <= CUR_W'(column_index);
				gpage_q  <= PAGE_W'(page_index);
			end
		end else if (state_q == ST_CHAR) begin
			cursor_q <= rotated_q ? cursor_q - 1'b1 : cursor_q + 1'b1;
		end else if (state_q == ST_READ && loc_ok_q) begin
			pend_q <= rotated_q ? mirror_byte(mem_rdata) : mem_rdata;
		end
	end

	// result register, loaded on the way out of the done state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign read_data    = result_q;

	// frame store
	pfgw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// no store write while idle, waiting on read data or handing off a result
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_en && mem_we &&
		  (state_q == ST_IDLE || state_q == ST_READ || state_q == ST_DONE)))
		else $error("store written outside a write state");

	// an accepted read byte moves to the read state in the next cycle, where the ram data arrives
	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && operation == OP_READ_BYTE) |=> (state_q == ST_READ))
		else $error("read byte did not enter the read state");

	// a free output slot lets the finished result out at once
	a_done_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && result_valid))
		else $error("finished result not presented");

	// glyph writes stop after the last column
	a_glyph_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHAR) |-> (gcnt_q <= CNT_W'(GLYPH_W - 1)))
		else $error("glyph column counter overran");

endmodule

`default_nettype wire

### hw/rtl/pfgw_ram.sv
// generic single-port synchronous ram with registered read
`default_nettype none

module pfgw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one access per cycle, write or read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench of the page frame store glyph writer
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfgw_pkg::*;

	localparam int FB_COLS   = COLUMNS_DEF;
	localparam int FB_PAGES  = ROWS_DEF / 8;
	localparam int RUN_LIMIT = 800000;

	// font for codes 32 to 127, column 0 in the top byte
	localparam logic [39:0] FONT [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0807030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h00B0700000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
		40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
		40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201590906,
		40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141413E, 40'h7F49494949, 40'h7F09090909, 40'h3E41415173,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h070B000000, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
		40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
		40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
		40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
		40'h0000770000, 40'h0041360800, 40'h0402040804, 40'h007F417F00
	};

	typedef struct {
		op_t              op;
		logic [DATA_W-1:0] data;
	} expected_read_t;

	logic                    clk;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	logic [OP_W-1:0]         operation;
	logic [PIX_X_W-1:0]      pixel_x;
	logic [PIX_Y_W-1:0]      pixel_y;
	logic [CODE_W-1:0]       char_code;
	logic [PAGE_IDX_W-1:0]   page_index;
	logic [COL_IDX_W-1:0]    column_index;
	logic                    result_valid;
	logic                    result_stall;
	logic [DATA_W-1:0]       read_data;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic                    cfg_data;

	// predicted frame contents and rotation setting
	logic [7:0]     frame_bytes [FB_COLS][FB_PAGES];
	logic           rotated_cfg;
	expected_read_t pending_reads[$];

	int error_count;
	int checked_count;
	int op_count [4];
	int nonzero_reads;
	int rotation_writes;
	int burst_left;
	int cycle_count;

	page_framebuffer_glyph_writer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.char_code    (char_code),
		.page_index   (page_index),
		.column_index (column_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_reads.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// reversed bit order of one byte
	function automatic logic [7:0] bit_reverse(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	// apply one operation to the predicted frame, return the byte the block should give back
	function automatic logic [7:0] frame_op_result(input op_t op, input logic [6:0] px,
			input logic [5:0] py, input logic [7:0] code, input logic [2:0] page,
			input logic [6:0] col);
		logic [7:0] result;
		int         glyph;
		int         c;
		int         p;
		result = 8'h00;
		case (op)
			OP_CLEAR: begin
				for (int x = 0; x < FB_COLS; x++)
					for (int y = 0; y < FB_PAGES; y++)
						frame_bytes[x][y] = 8'h00;
			end
			OP_SET_PIXEL: begin
				frame_bytes[px][py[5:3]] = frame_bytes[px][py[5:3]] | (8'h80 >> py[2:0]);
			end
			OP_PUT_CHAR: begin
				glyph = (code < 8'd32 || code > 8'd127) ? 0 : int'(code) - 32;
				for (int i = 0; i < GLYPH_W; i++) begin
					if (rotated_cfg) begin
						c = FB_COLS - int'(col) - i;
						p = FB_PAGES - 1 - int'(page);
					end else begin
						c = int'(col) + i;
						p = int'(page);
					end
					// glyph columns past either edge are dropped
					if (c >= 0 && c < FB_COLS)
						frame_bytes[c][p] = FONT[glyph][39 - 8*i -: 8];
				end
			end
			default: begin
				result = frame_bytes[col][page];
				if (rotated_cfg)
					result = bit_reverse(result);
			end
		endcase
		return result;
	endfunction

	task automatic report_mismatch(input string what, input op_t op, input logic [7:0] want,
			input logic [7:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch @%0t: %s (op %s) expected %02h got %02h", $realtime, what,
				op.name(), want, got);
	endtask

	// result checking
	always @(posedge clk) begin : check_results
		expected_read_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("result with no transaction pending", OP_CLEAR, 8'hxx, read_data);
			end else begin
				want = pending_reads.pop_front();
				checked_count++;
				if (read_data !== want.data)
					report_mismatch("read_data", want.op, want.data, read_data);
			end
		end
	end

	// result side backpressure, switching between patterns
	initial begin : result_backpressure
		int mode;
		int left;
		mode = 0;
		left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 9) < 3);
				2: result_stall <= ($urandom_range(0, 9) < 7);
				default: result_stall <= ((left % 5) < 2);
			endcase
		end
	end

	// send one transaction in bursts with random gaps, predict its result on acceptance
	task automatic send_item(input op_t op, input logic [6:0] px, input logic [5:0] py,
			input logic [7:0] code, input logic [2:0] page, input logic [6:0] col);
		int             gap;
		expected_read_t e;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid   <= 1'b1;
		operation    <= op;
		pixel_x      <= px;
		pixel_y      <= py;
		char_code    <= code;
		page_index   <= page;
		column_index <= col;
		do @(posedge clk); while (item_stall !== 1'b0);
		e.op   = op;
		e.data = frame_op_result(op, px, py, code, page, col);
		pending_reads.push_back(e);
		op_count[op]++;
		if (op == OP_READ_BYTE && e.data != 8'h00)
			nonzero_reads++;
	endtask

	task automatic do_clear();
		send_item(OP_CLEAR, 7'($urandom), 6'($urandom), 8'($urandom), 3'($urandom),
			7'($urandom));
	endtask

	task automatic put_pixel(input logic [6:0] x, input logic [5:0] y);
		send_item(OP_SET_PIXEL, x, y, 8'($urandom), 3'($urandom), 7'($urandom));
	endtask

	task automatic put_char(input logic [7:0] code, input logic [2:0] page,
			input logic [6:0] col);
		send_item(OP_PUT_CHAR, 7'($urandom), 6'($urandom), code, page, col);
	endtask

	task automatic read_cell(input logic [2:0] page, input logic [6:0] col);
		send_item(OP_READ_BYTE, 7'($urandom), 6'($urandom), 8'($urandom), page, col);
	endtask

	// stop sending and wait for every pending result
	task automatic finish_phase();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_reads.size() != 0) @(posedge clk);
	endtask

	task automatic set_rotation(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		rotated_cfg = v;
		rotation_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// store must read back empty after the reset sweep
	task automatic test_cleared_after_reset();
		set_rotation(1'b0);
		read_cell(3'd0, 7'd0);
		read_cell(3'd7, 7'd127);
	endtask

	// pixels at the corners and the middle, bit 7 being the top row of a page
	task automatic test_pixel_corners();
		put_pixel(7'd0, 6'd0);
		put_pixel(7'd127, 6'd63);
		put_pixel(7'd64, 6'd37);
		read_cell(3'd0, 7'd0);
		read_cell(3'd7, 7'd127);
		read_cell(3'd4, 7'd64);
	endtask

	// upright glyphs: code range edges, unsupported codes and right edge clipping
	task automatic test_glyphs_upright();
		put_char(8'd65, 3'd0, 7'd125);
		put_char(8'd255, 3'd7, 7'd127);
		put_char(8'd127, 3'd3, 7'd0);
		put_char(8'd31, 3'd2, 7'd10);
		put_char(8'd32, 3'd2, 7'd11);
		read_cell(3'd0, 7'd127);
		read_cell(3'd3, 7'd2);
	endtask

	task automatic test_clear();
		do_clear();
		read_cell(3'd0, 7'd126);
	endtask

	// rotated glyphs: mirrored placement, both column edges, reversed reads
	task automatic test_glyphs_rotated();
		finish_phase();
		set_rotation(1'b1);
		put_char(8'd66, 3'd0, 7'd0);
		put_char(8'd87, 3'd5, 7'd127);
		put_char(8'd128, 3'd6, 7'd60);
		put_pixel(7'd3, 6'd9);
		read_cell(3'd7, 7'd127);
		read_cell(3'd2, 7'd0);
		read_cell(3'd1, 7'd3);
		finish_phase();
		set_rotation(1'b0);
	endtask

	// random traffic in phases, alternating rotation between phases
	task automatic test_random_traffic(input int phases, input int per_phase);
		int         r;
		logic [6:0] last_col;
		logic [2:0] last_page;
		logic [6:0] col;
		logic [7:0] code;
		last_col  = '0;
		last_page = '0;
		for (int ph = 0; ph < phases; ph++) begin
			finish_phase();
			set_rotation(ph[0]);
			for (int n = 0; n < per_phase; n++) begin
				r = $urandom_range(0, 999);
				if (r < 15) begin
					do_clear();
				end else if (r < 350) begin
					put_pixel(7'($urandom), 6'($urandom));
				end else if (r < 650) begin
					// favor printable codes and the column edges
					code = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
						8'($urandom_range(32, 127));
					case ($urandom_range(0, 6))
						0: col = 7'($urandom_range(0, 4));
						1: col = 7'($urandom_range(123, 127));
						default: col = 7'($urandom);
					endcase
					last_col  = col;
					last_page = 3'($urandom);
					put_char(code, last_page, col);
				end else if ($urandom_range(0, 1) == 0) begin
					// read back around the last glyph, either orientation
					if (rotated_cfg)
						read_cell(3'd7 - last_page, 7'(8'd128 - last_col - 8'($urandom_range(0, 4))));
					else
						read_cell(last_page, last_col + 7'($urandom_range(0, 4)));
				end else begin
					read_cell(3'($urandom), 7'($urandom));
				end
			end
		end
		finish_phase();
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		operation    = '0;
		pixel_x      = '0;
		pixel_y      = '0;
		char_code    = '0;
		page_index   = '0;
		column_index = '0;
		cfg_valid    = 1'b0;
		cfg_data     = 1'b0;
		rotated_cfg  = 1'b0;
		error_count  = 0;
		checked_count = 0;
		nonzero_reads = 0;
		rotation_writes = 0;
		burst_left   = 0;
		cycle_count  = 0;
		op_count     = '{default: 0};
		for (int x = 0; x < FB_COLS; x++)
			for (int y = 0; y < FB_PAGES; y++)
				frame_bytes[x][y] = 8'h00;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_cleared_after_reset();
		test_pixel_corners();
		test_glyphs_upright();
		test_clear();
		test_glyphs_rotated();
		test_random_traffic(8, 200);

		repeat (40) @(posedge clk);
		if (pending_reads.size() != 0)
			error_count++;

		$display("sent %0d clears, %0d pixels, %0d glyphs, %0d reads (%0d non-zero)",
			op_count[OP_CLEAR], op_count[OP_SET_PIXEL], op_count[OP_PUT_CHAR],
			op_count[OP_READ_BYTE], nonzero_reads);
		$display("%0d results checked over %0d rotation writes, %0d mismatches",
			checked_count, rotation_writes, error_count);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
